// ===== design/pom_pkg.sv =====
package pom_pkg;

    // Width of the rising-edge counter and of the window register
    localparam int CNT_WIDTH = 32;
    localparam int CFG_WIDTH = 32;

    localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = CFG_WIDTH'(10000000);

    // What the back end does with one queued item
    typedef enum logic [1:0] {
        OP_KEEP = 2'd0,
        OP_RISE = 2'd1,
        OP_FALL = 2'd2
    } op_kind_t;

    localparam int OP_WIDTH = $bits(op_kind_t);

endpackage

// ===== design/pom_front.sv =====
module pom_front
    import pom_pkg::*;
#(
    parameter int TIME_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  pin_level,
    input  logic [TIME_WIDTH-1:0] timestamp_us,
    input  logic                  q_full,
    output logic                  q_push,
    output op_kind_t              q_kind,
    output logic [TIME_WIDTH-1:0] q_dt
);

    logic                  started_reg;
    logic                  started_next;
    logic                  line_level_reg;
    logic                  line_level_next;
    logic [TIME_WIDTH-1:0] last_change_reg;
    logic [TIME_WIDTH-1:0] last_change_next;
    logic                  accept;
    logic                  changed;

    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;
    assign q_push   = accept;
    assign changed  = started_reg & (pin_level != line_level_reg);

    // Elapsed time wraps with the timestamp
    assign q_dt = timestamp_us - last_change_reg;

    always_comb
    begin
        if (changed)
        begin
            q_kind = pin_level ? OP_RISE : OP_FALL;
        end
        else
        begin
            q_kind = OP_KEEP;
        end
    end

    always_comb
    begin
        started_next     = started_reg;
        line_level_next  = line_level_reg;
        last_change_next = last_change_reg;
        if (accept && (!started_reg || changed))
        begin
            started_next     = 1'b1;
            line_level_next  = pin_level;
            last_change_next = timestamp_us;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg     <= 1'b0;
            line_level_reg  <= 1'b0;
            last_change_reg <= '0;
        end
        else
        begin
            started_reg     <= started_next;
            line_level_reg  <= line_level_next;
            last_change_reg <= last_change_next;
        end
    end

endmodule

// ===== design/pom_queue.sv =====
module pom_queue
#(
    parameter int WIDTH = 34,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW:0]      wr_ptr_reg;
    logic [AW:0]      wr_ptr_next;
    logic [AW:0]      rd_ptr_reg;
    logic [AW:0]      rd_ptr_next;

    assign empty    = (wr_ptr_reg == rd_ptr_reg);
    assign full     = (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0])
                      && (wr_ptr_reg[AW] != rd_ptr_reg[AW]);
    assign pop_data = entry_reg[rd_ptr_reg[AW-1:0]];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push && !full)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg[AW-1:0]] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

// ===== design/pom_back.sv =====
module pom_back
    import pom_pkg::*;
#(
    parameter int TIME_WIDTH    = 32,
    parameter int ACCUM_WIDTH   = 48,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_WIDTH-1:0]     cfg_wdata,
    input  logic                     q_empty,
    output logic                     q_pop,
    input  op_kind_t                 q_kind,
    input  logic [TIME_WIDTH-1:0]    q_dt,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     window_done,
    output logic [ACCUM_WIDTH-1:0]   total_time,
    output logic [ACCUM_WIDTH-1:0]   high_time,
    output logic [ACCUM_WIDTH-1:0]   low_time,
    output logic [CNT_WIDTH-1:0]     pulse_count,
    output logic [FRACTION_BITS-1:0] occupancy
);

    localparam int SUM_W = ((TIME_WIDTH > ACCUM_WIDTH) ? TIME_WIDTH : ACCUM_WIDTH) + 1;
    localparam int CW    = $clog2(FRACTION_BITS + 1);

    localparam logic [SUM_W-1:0] ACC_MAX = SUM_W'({ACCUM_WIDTH{1'b1}});

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_DIV   = 3'b100
    } back_state_t;

    back_state_t              state_reg,        state_next;
    op_kind_t                 kind_reg,         kind_next;
    logic [CFG_WIDTH-1:0]     window_reg,       window_next;
    logic [ACCUM_WIDTH-1:0]   total_accum_reg,  total_accum_next;
    logic [ACCUM_WIDTH-1:0]   high_accum_reg,   high_accum_next;
    logic [ACCUM_WIDTH-1:0]   low_accum_reg,    low_accum_next;
    logic [CNT_WIDTH-1:0]     edge_accum_reg,   edge_accum_next;
    logic [ACCUM_WIDTH-1:0]   held_total_reg,   held_total_next;
    logic [ACCUM_WIDTH-1:0]   held_high_reg,    held_high_next;
    logic [ACCUM_WIDTH-1:0]   held_low_reg,     held_low_next;
    logic [CNT_WIDTH-1:0]     held_count_reg,   held_count_next;
    logic [FRACTION_BITS-1:0] held_occ_reg,     held_occ_next;
    logic [ACCUM_WIDTH-1:0]   div_rem_reg,      div_rem_next;
    logic [CW-1:0]            div_cnt_reg,      div_cnt_next;
    logic                     out_valid_reg,    out_valid_next;
    logic                     done_reg,         done_next;

    logic [SUM_W-1:0]         dt_ext;
    logic [SUM_W-1:0]         total_sum;
    logic [SUM_W-1:0]         high_sum;
    logic [SUM_W-1:0]         low_sum;
    logic [ACCUM_WIDTH-1:0]   total_sat;
    logic [ACCUM_WIDTH-1:0]   high_sat;
    logic [ACCUM_WIDTH-1:0]   low_sat;
    logic                     window_full;
    logic                     closing;
    logic [ACCUM_WIDTH:0]     rem_dbl;
    logic [ACCUM_WIDTH:0]     rem_sub;
    logic                     rem_ge;
    logic                     out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty && out_free;

    // Saturating accumulate of the elapsed time
    assign dt_ext    = SUM_W'(q_dt);
    assign total_sum = SUM_W'(total_accum_reg) + dt_ext;
    assign high_sum  = SUM_W'(high_accum_reg) + dt_ext;
    assign low_sum   = SUM_W'(low_accum_reg) + dt_ext;
    assign total_sat = (total_sum > ACC_MAX) ? '1 : total_sum[ACCUM_WIDTH-1:0];
    assign high_sat  = (high_sum > ACC_MAX) ? '1 : high_sum[ACCUM_WIDTH-1:0];
    assign low_sat   = (low_sum > ACC_MAX) ? '1 : low_sum[ACCUM_WIDTH-1:0];

    assign window_full = (total_accum_reg >= ACCUM_WIDTH'(window_reg));
    assign closing     = (kind_reg != OP_KEEP) && window_full;

    // One quotient bit per cycle: compare twice the remainder with the total
    assign rem_dbl = {div_rem_reg, 1'b0};
    assign rem_sub = rem_dbl - {1'b0, held_total_reg};
    assign rem_ge  = (rem_dbl >= {1'b0, held_total_reg});

    always_comb
    begin
        state_next       = state_reg;
        kind_next        = kind_reg;
        window_next      = window_reg;
        total_accum_next = total_accum_reg;
        high_accum_next  = high_accum_reg;
        low_accum_next   = low_accum_reg;
        edge_accum_next  = edge_accum_reg;
        held_total_next  = held_total_reg;
        held_high_next   = held_high_reg;
        held_low_next    = held_low_reg;
        held_count_next  = held_count_reg;
        held_occ_next    = held_occ_reg;
        div_rem_next     = div_rem_reg;
        div_cnt_next     = div_cnt_reg;
        out_valid_next   = out_valid_reg;
        done_next        = done_reg;

        if (cfg_we)
        begin
            window_next = cfg_wdata;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    kind_next  = q_kind;
                    state_next = S_CHECK;
                    case (q_kind)
                        OP_RISE:
                        begin
                            total_accum_next = total_sat;
                            high_accum_next  = high_sat;
                            if (edge_accum_reg != '1)
                            begin
                                edge_accum_next = edge_accum_reg + 1'b1;
                            end
                        end
                        OP_FALL:
                        begin
                            total_accum_next = total_sat;
                            low_accum_next   = low_sat;
                        end
                        default:
                        begin
                            total_accum_next = total_accum_reg;
                        end
                    endcase
                end
            end
            S_CHECK:
            begin
                done_next = closing;
                if (closing)
                begin
                    held_total_next  = total_accum_reg;
                    held_high_next   = high_accum_reg;
                    held_low_next    = low_accum_reg;
                    held_count_next  = edge_accum_reg;
                    total_accum_next = '0;
                    high_accum_next  = '0;
                    low_accum_next   = '0;
                    edge_accum_next  = '0;
                    div_rem_next     = low_accum_reg;
                    div_cnt_next     = CW'(FRACTION_BITS);
                    if (total_accum_reg == '0)
                    begin
                        held_occ_next  = '0;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else if (low_accum_reg >= total_accum_reg)
                    begin
                        held_occ_next  = '1;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        held_occ_next = '0;
                        state_next    = S_DIV;
                    end
                end
                else
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DIV:
            begin
                // Shift the quotient straight into the held occupancy
                held_occ_next = {held_occ_reg[FRACTION_BITS-2:0], rem_ge};
                div_rem_next  = rem_ge ? rem_sub[ACCUM_WIDTH-1:0]
                                       : rem_dbl[ACCUM_WIDTH-1:0];
                div_cnt_next  = div_cnt_reg - 1'b1;
                if (div_cnt_reg == CW'(1))
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            kind_reg        <= OP_KEEP;
            window_reg      <= WINDOW_RESET;
            total_accum_reg <= '0;
            high_accum_reg  <= '0;
            low_accum_reg   <= '0;
            edge_accum_reg  <= '0;
            held_total_reg  <= '0;
            held_high_reg   <= '0;
            held_low_reg    <= '0;
            held_count_reg  <= '0;
            held_occ_reg    <= '0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            kind_reg        <= kind_next;
            window_reg      <= window_next;
            total_accum_reg <= total_accum_next;
            high_accum_reg  <= high_accum_next;
            low_accum_reg   <= low_accum_next;
            edge_accum_reg  <= edge_accum_next;
            held_total_reg  <= held_total_next;
            held_high_reg   <= held_high_next;
            held_low_reg    <= held_low_next;
            held_count_reg  <= held_count_next;
            held_occ_reg    <= held_occ_next;
            div_cnt_reg     <= div_cnt_next;
            out_valid_reg   <= out_valid_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_rem_reg <= div_rem_next;
    end

    assign out_valid   = out_valid_reg;
    assign window_done = done_reg;
    assign total_time  = held_total_reg;
    assign high_time   = held_high_reg;
    assign low_time    = held_low_reg;
    assign pulse_count = held_count_reg;
    assign occupancy   = held_occ_reg;

    a_low_within_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (held_low_reg <= held_total_reg))
        else $error("held low time exceeds held total time");

    a_no_result_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> !out_valid_reg)
        else $error("result shown while occupancy is still being divided");

    a_close_clears_accums: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_CHECK) && closing) |=> (total_accum_reg == '0)
                                                && (edge_accum_reg == '0))
        else $error("accumulators not cleared after window close");

    a_pop_needs_free_output: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !(out_valid_reg && out_stall))
        else $error("item popped while a stalled result is pending");

    a_done_meets_window: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> (held_total_reg >= ACCUM_WIDTH'(window_reg)))
        else $error("window closed below its length");

endmodule

// ===== design/pulse_occupancy_meter.sv =====
// Channel   Handshake           Payload
// input     in_valid/in_stall   pin_level, timestamp_us
// output    out_valid/out_stall window_done, total_time, high_time, low_time,
//                               pulse_count, occupancy
// config    cfg_we              cfg_wdata (window_length)
//
// An item that does not close a window passes S_IDLE and S_CHECK in the back
// end after it leaves the 4-entry queue; so does one that closes a window with
// zero total or all-low time. Any other close also passes S_DIV, where the
// one-bit-per-cycle occupancy divider produces the FRACTION_BITS quotient bits.
// The front end takes one item per cycle until the queue fills.
// Reset clears all accumulators and held results; the window returns to 10000000.
// in_stall is high while the queue is full; a stalled result holds the back end.
module pulse_occupancy_meter
    import pom_pkg::*;
#(
    parameter int TIME_WIDTH    = 32,
    parameter int ACCUM_WIDTH   = 48,
    parameter int FRACTION_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_WIDTH-1:0]     cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     pin_level,
    input  logic [TIME_WIDTH-1:0]    timestamp_us,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     window_done,
    output logic [ACCUM_WIDTH-1:0]   total_time,
    output logic [ACCUM_WIDTH-1:0]   high_time,
    output logic [ACCUM_WIDTH-1:0]   low_time,
    output logic [CNT_WIDTH-1:0]     pulse_count,
    output logic [FRACTION_BITS-1:0] occupancy
);

    localparam int Q_WIDTH = OP_WIDTH + TIME_WIDTH;
    localparam int Q_DEPTH = 4;

    logic                  q_full;
    logic                  q_empty;
    logic                  q_push;
    logic                  q_pop;
    op_kind_t              push_kind;
    logic [TIME_WIDTH-1:0] push_dt;
    logic [Q_WIDTH-1:0]    pop_data;
    op_kind_t              pop_kind;
    logic [TIME_WIDTH-1:0] pop_dt;

    pom_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pin_level    (pin_level),
        .timestamp_us (timestamp_us),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_kind       (push_kind),
        .q_dt         (push_dt)
    );

    pom_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_kind, push_dt}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    assign pop_kind = op_kind_t'(pop_data[Q_WIDTH-1:TIME_WIDTH]);
    assign pop_dt   = pop_data[TIME_WIDTH-1:0];

    pom_back #(
        .TIME_WIDTH    (TIME_WIDTH),
        .ACCUM_WIDTH   (ACCUM_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .q_kind      (pop_kind),
        .q_dt        (pop_dt),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .window_done (window_done),
        .total_time  (total_time),
        .high_time   (high_time),
        .low_time    (low_time),
        .pulse_count (pulse_count),
        .occupancy   (occupancy)
    );

endmodule

// ===== sim/pulse_occupancy_meter_tb.sv =====
module pulse_occupancy_meter_tb
    import pom_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TW = 32;
    localparam int AW = 48;
    localparam int FW = 16;

    typedef struct packed {
        logic          done;
        logic [AW-1:0] total;
        logic [AW-1:0] high;
        logic [AW-1:0] low;
        logic [CNT_WIDTH-1:0] count;
        logic [FW-1:0] occ;
    } window_report_t;

    class window_tracker;
        logic [CFG_WIDTH-1:0] window_len;
        bit                   started;
        logic                 line_lvl;
        logic [TW-1:0]        last_ts;
        logic [AW-1:0]        tot_acc, hi_acc, lo_acc;
        logic [CNT_WIDTH-1:0] edge_acc;
        logic [AW-1:0]        held_tot, held_hi, held_lo;
        logic [CNT_WIDTH-1:0] held_cnt;
        logic [FW-1:0]        held_occ;
        window_report_t       pending_reports[$];
        int                   errors;

        function new();
            window_len = WINDOW_RESET;
            started  = 1'b0;
            line_lvl = 1'b0;
            last_ts  = '0;
            tot_acc  = '0;
            hi_acc   = '0;
            lo_acc   = '0;
            edge_acc = '0;
            held_tot = '0;
            held_hi  = '0;
            held_lo  = '0;
            held_cnt = '0;
            held_occ = '0;
            errors   = 0;
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        function logic [AW-1:0] add_time(logic [AW-1:0] acc, logic [TW-1:0] dt);
            logic [AW:0] sum;
            sum = {1'b0, acc} + (AW+1)'(dt);
            return sum[AW] ? {AW{1'b1}} : sum[AW-1:0];
        endfunction

        function logic [FW-1:0] low_fraction(logic [AW-1:0] lo, logic [AW-1:0] tot);
            logic [63:0] num, den;
            if (tot == '0)
                return '0;
            if (lo >= tot)
                return {FW{1'b1}};
            num = 64'(lo) << FW;
            den = 64'(tot);
            return FW'(num / den);
        endfunction

        function void take_sample(logic lvl, logic [TW-1:0] ts);
            window_report_t rep;
            logic [TW-1:0]  dt;
            rep = '0;
            if (!started) begin
                started  = 1'b1;
                line_lvl = lvl;
                last_ts  = ts;
            end
            else if (lvl != line_lvl) begin
                dt = ts - last_ts;
                tot_acc = add_time(tot_acc, dt);
                if (lvl) begin
                    hi_acc = add_time(hi_acc, dt);
                    if (edge_acc != {CNT_WIDTH{1'b1}})
                        edge_acc = edge_acc + 1'b1;
                end
                else
                    lo_acc = add_time(lo_acc, dt);
                if (tot_acc >= AW'(window_len)) begin
                    held_tot = tot_acc;
                    held_hi  = hi_acc;
                    held_lo  = lo_acc;
                    held_cnt = edge_acc;
                    held_occ = low_fraction(lo_acc, tot_acc);
                    tot_acc  = '0;
                    hi_acc   = '0;
                    lo_acc   = '0;
                    edge_acc = '0;
                    rep.done = 1'b1;
                end
                line_lvl = lvl;
                last_ts  = ts;
            end
            rep.total = held_tot;
            rep.high  = held_hi;
            rep.low   = held_lo;
            rep.count = held_cnt;
            rep.occ   = held_occ;
            pending_reports.push_back(rep);
        endfunction

        function void field_ok(string name, logic [AW-1:0] want, logic [AW-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_report(window_report_t got);
            window_report_t want;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual done=%0b total=%0h",
                         $time, got.done, got.total);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            field_ok("window_done", AW'(want.done), AW'(got.done));
            field_ok("total_time", want.total, got.total);
            field_ok("high_time", want.high, got.high);
            field_ok("low_time", want.low, got.low);
            field_ok("pulse_count", AW'(want.count), AW'(got.count));
            field_ok("occupancy", AW'(want.occ), AW'(got.occ));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_WIDTH-1:0] cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 pin_level = 1'b0;
    logic [TW-1:0]        timestamp_us = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 window_done;
    logic [AW-1:0]        total_time;
    logic [AW-1:0]        high_time;
    logic [AW-1:0]        low_time;
    logic [CNT_WIDTH-1:0] pulse_count;
    logic [FW-1:0]        occupancy;

    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;

    window_tracker tracker = new();

    pulse_occupancy_meter #(
        .TIME_WIDTH   (TW),
        .ACCUM_WIDTH  (AW),
        .FRACTION_BITS(FW)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pin_level   (pin_level),
        .timestamp_us(timestamp_us),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .window_done (window_done),
        .total_time  (total_time),
        .high_time   (high_time),
        .low_time    (low_time),
        .pulse_count (pulse_count),
        .occupancy   (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: check on accept, then pick the next stall
    initial
    begin
        window_report_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.done  = window_done;
                got.total = total_time;
                got.high  = high_time;
                got.low   = low_time;
                got.count = pulse_count;
                got.occ   = occupancy;
                tracker.check_report(got);
            end
            out_stall <= ($urandom_range(99, 0) < sink_stall_pct);
        end
    end

    task automatic send_sample(input logic lvl, input logic [TW-1:0] ts);
        if ($urandom_range(99, 0) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99, 0) < sender_idle_pct);
        end
        in_valid     <= 1'b1;
        pin_level    <= lvl;
        timestamp_us <= ts;
        do @(posedge clk); while (in_stall);
        tracker.take_sample(lvl, ts);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        // let the divider settle before touching the register
        repeat (40) @(posedge clk);
    endtask

    task automatic write_window(input logic [CFG_WIDTH-1:0] len);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.window_len = len;
    endtask

    initial
    begin
        logic [CFG_WIDTH-1:0] phase_window [8];
        logic [TW-1:0]        ts;
        logic [TW-1:0]        step_max;
        logic                 lvl;
        int                   mode;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset window: timestamp wrap, unchanged level, then a closing rise
        send_sample(1'b1, 32'hFFFF_FFF0);
        send_sample(1'b1, 32'h0000_0000);
        send_sample(1'b0, 32'h0000_0100);
        send_sample(1'b1, 32'h0100_0000);
        wait_drained();

        // Shortest window: all-low windows saturate occupancy
        write_window(32'd1);
        send_sample(1'b0, 32'h0000_0005);
        send_sample(1'b1, 32'h0000_0005);
        send_sample(1'b0, 32'h0000_0006);
        send_sample(1'b1, 32'hFFFF_FFFF);
        wait_drained();

        // Zero window: zero elapsed time closes with zero occupancy
        write_window(32'd0);
        send_sample(1'b0, 32'hFFFF_FFFF);
        send_sample(1'b1, 32'hFFFF_FFFF);
        send_sample(1'b1, 32'h0000_0000);
        wait_drained();

        // Longest window: two half-range elapsed times, half occupancy
        write_window(32'hFFFF_FFFF);
        send_sample(1'b0, 32'hFFFF_FFFE);
        send_sample(1'b1, 32'h7FFF_FFFE);
        send_sample(1'b0, 32'hFFFF_FFFE);
        wait_drained();

        phase_window = '{32'd1, 32'd500, 32'hFFFF_FFFF, 32'd10000000,
                         32'd0, 32'd3000, 32'd40, 32'd2};
        phase_window[7] = $urandom_range(100000, 2);
        ts  = $urandom;
        lvl = 1'($urandom_range(1, 0));

        for (int p = 0; p < 8; p++)
        begin
            mode = p % 4;
            sender_idle_pct = (mode == 1) ? 65 : (mode == 3) ? 28 : 0;
            sink_stall_pct  = (mode == 2) ? 65 : (mode == 3) ? 28 : 0;
            write_window(phase_window[p]);
            if (phase_window[p] <= 1)
                step_max = 3;
            else
                step_max = phase_window[p] / 2;
            for (int i = 0; i < 190; i++)
            begin
                if ($urandom_range(99, 0) < 75)
                    lvl = ~lvl;
                if ($urandom_range(99, 0) < 5 || phase_window[p] == 32'hFFFF_FFFF)
                    ts = $urandom;
                else
                    ts = ts + $urandom_range(step_max, 0);
                send_sample(lvl, ts);
                // hold off mid-phase until every result is back
                if (p == 2 && i == 95)
                    wait_drained();
            end
            wait_drained();
        end

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
